FILE: hdl/epc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package epc_pkg;

   // Field and register widths
   localparam int TARGET_WIDTH        = 10;
   localparam int GAIN_WIDTH          = 16;
   localparam int POS_WIDTH           = 16;
   localparam int DRIVE_WIDTH         = 8;
   localparam int INTEG_WIDTH         = 32;
   localparam int COUNT_WIDTH_DEFAULT = 16;

   // Configuration port
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TARGET_DEG = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PROP_GAIN  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_INT_GAIN   = 2'd2;

   // Register reset values
   localparam logic [TARGET_WIDTH-1:0] TARGET_RESET = 10'd45;
   localparam logic [GAIN_WIDTH-1:0]   PROP_RESET   = 16'd4915;
   localparam logic [GAIN_WIDTH-1:0]   INT_RESET    = 16'd82;

   // Position error in Q8 degrees: err = target*256 - floor(count*7680/19).
   // Only counts below 1024 can be below target, so the quotient is tracked
   // incrementally: each step adds 7680/19 = 404 remainder 4.
   localparam int FRAC_BITS   = 8;
   localparam int LOW_BITS    = 10;
   localparam int QUOT_WIDTH  = 19;
   localparam int REM_WIDTH   = 5;
   localparam int ERR_WIDTH   = 18;
   localparam logic [QUOT_WIDTH-1:0] QUOT_STEP  = 19'd404;
   localparam logic [REM_WIDTH-1:0]  REM_STEP   = 5'd4;
   localparam logic [REM_WIDTH-1:0]  STEP_DIVISOR = 5'd19;

   // Target compare: count*360 < target*228 reduces to count*30 < target*19
   localparam int CMP_WIDTH = 15;
   localparam logic [CMP_WIDTH-1:0] CMP_COUNT_MUL  = 15'd30;
   localparam logic [CMP_WIDTH-1:0] CMP_TARGET_MUL = 15'd19;

   // Drive arithmetic: Q4.12 gains times Q8 values give Q20 products
   localparam int PPROD_WIDTH = GAIN_WIDTH + ERR_WIDTH;
   localparam int IPROD_WIDTH = GAIN_WIDTH + INTEG_WIDTH;
   localparam int SUM_WIDTH   = IPROD_WIDTH + 1;
   localparam int DRIVE_SHIFT = 20;

   function automatic logic below_target(input logic [LOW_BITS-1:0]     lo,
                                         input logic                    small_cnt,
                                         input logic [TARGET_WIDTH-1:0] target);
      logic [CMP_WIDTH-1:0] lhs;
      logic [CMP_WIDTH-1:0] rhs;
      lhs = CMP_WIDTH'(lo) * CMP_COUNT_MUL;
      rhs = CMP_WIDTH'(target) * CMP_TARGET_MUL;
      return small_cnt && (lhs < rhs);
   endfunction

endpackage

`default_nettype wire

FILE: hdl/epc_step_counter.sv
`timescale 1ns / 1ps
`default_nettype none

module epc_step_counter #(
   parameter int COUNT_WIDTH = epc_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   ch_a,
   input  wire logic                   ch_b,
   input  wire logic                   advance,
   input  wire logic                   clear,
   output logic [COUNT_WIDTH-1:0]      count,
   output logic [COUNT_WIDTH-1:0]      count_next,
   output logic                        stepped
);

   logic                   phase_ff;
   logic                   phase_in;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   logic                   level;

   // Count a step when the channel XOR leaves the stored phase; hold at max
   assign level    = ch_a ^ ch_b;
   assign stepped  = (level != phase_ff) && !(&count_ff);
   assign phase_in = level;

   always_comb begin
      if (clear) begin
         count_in = '0;
      end else if (stepped) begin
         count_in = count_ff + COUNT_WIDTH'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 1'b0;
         count_ff <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   assign count      = count_ff;
   assign count_next = count_in;

endmodule

`default_nettype wire

FILE: hdl/encoder_pi_position_control.sv
`timescale 1ns / 1ps
`default_nettype none

// Encoder step counters with a PI position loop for one motor.
// Input channel (req_): one pin sample per transfer, with both encoder
// channel pairs, the control tick and the clear flag. Result channel (rsp_):
// one result per sample, with the drive duty, both positions and at_target.
// Configuration (csr_): write target_deg, prop_gain or int_gain by index
// while the block is idle; unknown indexes are dropped.
// Throughput is one sample per cycle until a stalled result channel fills the
// pipeline. From an input transfer to its result, the counters and integral
// update at the transfer, the gain multiplies take the second stage and the
// drive sum and clamp the third, which is also the output register.
// Reset zeroes both counts, phase bits, the integral and the drive, and loads
// the register defaults (45 degrees, gains 4915 and 82).
// When the receiver stalls, the result holds and the pipeline fills behind
// it; req_stall rises only once all three stages hold a sample, so inputs
// keep flowing while a finished result waits.
module encoder_pi_position_control #(
   parameter int COUNT_WIDTH = epc_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // Sample channel
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_motor_ch_a,
   input  wire logic                                 req_motor_ch_b,
   input  wire logic                                 req_optical_ch_a,
   input  wire logic                                 req_optical_ch_b,
   input  wire logic                                 req_control_tick,
   input  wire logic                                 req_clear_counts,
   // Result channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [epc_pkg::DRIVE_WIDTH-1:0]           rsp_motor_drive,
   output logic [epc_pkg::POS_WIDTH-1:0]             rsp_motor_position,
   output logic [epc_pkg::POS_WIDTH-1:0]             rsp_optical_position,
   output logic                                      rsp_at_target,
   // Configuration port
   input  wire logic                                 csr_write,
   input  wire logic [epc_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  wire logic [epc_pkg::CSR_DATA_WIDTH-1:0]   csr_data
);

   import epc_pkg::*;

   localparam int EXT_WIDTH = (COUNT_WIDTH > LOW_BITS) ? COUNT_WIDTH : LOW_BITS;

   // Configuration registers
   logic [TARGET_WIDTH-1:0] target_ff;
   logic [GAIN_WIDTH-1:0]   prop_ff;
   logic [GAIN_WIDTH-1:0]   int_ff;

   // Handshake and stage valids
   logic accept;
   logic adv2;
   logic adv3;
   logic v1_ff, v1_in;
   logic v2_ff, v2_in;
   logic v3_ff, v3_in;

   // Counters
   logic [COUNT_WIDTH-1:0] motor_count;
   logic [COUNT_WIDTH-1:0] motor_next;
   logic                   motor_stepped;
   logic [COUNT_WIDTH-1:0] optical_count;
   logic [COUNT_WIDTH-1:0] optical_next;
   logic                   optical_stepped;

   // Quotient tracker and loop state
   logic [QUOT_WIDTH-1:0]  quot_ff, quot_in;
   logic [REM_WIDTH-1:0]   rem_ff, rem_in;
   logic [REM_WIDTH-1:0]   rem_sum;
   logic [INTEG_WIDTH-1:0] integ_ff, integ_in;
   logic [INTEG_WIDTH:0]   integ_sum;

   logic [EXT_WIDTH-1:0]   motor_old_ext;
   logic [EXT_WIDTH-1:0]   motor_new_ext;
   logic                   below_old;
   logic                   below_new;
   logic [QUOT_WIDTH-1:0]  err_full;
   logic [ERR_WIDTH-1:0]   err;

   // Stage 1
   logic [ERR_WIDTH-1:0]   err1_ff;
   logic [INTEG_WIDTH-1:0] integ1_ff;
   logic                   tick1_ff, below1_ff, clr1_ff, at1_ff;
   logic [POS_WIDTH-1:0]   mpos1_ff, opos1_ff;

   // Stage 2
   logic [PPROD_WIDTH-1:0] pprod2_ff;
   logic [IPROD_WIDTH-1:0] iprod2_ff;
   logic                   tick2_ff, below2_ff, clr2_ff, at2_ff;
   logic [POS_WIDTH-1:0]   mpos2_ff, opos2_ff;

   // Stage 3 (output register; the drive is also the held duty)
   logic [DRIVE_WIDTH-1:0] drive_ff, drive_in;
   logic [SUM_WIDTH-1:0]   drive_sum;
   logic [SUM_WIDTH-1:0]   drive_shifted;
   logic [DRIVE_WIDTH-1:0] drive_clamped;
   logic                   at3_ff;
   logic [POS_WIDTH-1:0]   mpos3_ff, opos3_ff;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= TARGET_RESET;
         prop_ff   <= PROP_RESET;
         int_ff    <= INT_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_TARGET_DEG: target_ff <= csr_data[TARGET_WIDTH-1:0];
            CSR_PROP_GAIN:  prop_ff   <= csr_data[GAIN_WIDTH-1:0];
            CSR_INT_GAIN:   int_ff    <= csr_data[GAIN_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Advance the pipeline; a stage moves on when the next one frees up
   assign adv3      = v2_ff && (!v3_ff || !rsp_stall);
   assign adv2      = v1_ff && (!v2_ff || adv3);
   assign req_stall = v1_ff && !adv2;
   assign accept    = req_valid && !req_stall;
   assign v1_in     = accept || (v1_ff && !adv2);
   assign v2_in     = adv2 || (v2_ff && !adv3);
   assign v3_in     = adv3 || (v3_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   epc_step_counter #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_motor_counter (
      .clock      (clock),
      .reset      (reset),
      .ch_a       (req_motor_ch_a),
      .ch_b       (req_motor_ch_b),
      .advance    (accept),
      .clear      (req_clear_counts),
      .count      (motor_count),
      .count_next (motor_next),
      .stepped    (motor_stepped)
   );

   epc_step_counter #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_optical_counter (
      .clock      (clock),
      .reset      (reset),
      .ch_a       (req_optical_ch_a),
      .ch_b       (req_optical_ch_b),
      .advance    (accept),
      .clear      (req_clear_counts),
      .count      (optical_count),
      .count_next (optical_next),
      .stepped    (optical_stepped)
   );

   // Compare motor counts against the target before and after this sample
   assign motor_old_ext = EXT_WIDTH'(motor_count);
   assign motor_new_ext = EXT_WIDTH'(motor_next);
   assign below_old = below_target(motor_old_ext[LOW_BITS-1:0],
                                   (motor_old_ext >> LOW_BITS) == '0, target_ff);
   assign below_new = below_target(motor_new_ext[LOW_BITS-1:0],
                                   (motor_new_ext >> LOW_BITS) == '0, target_ff);

   // Track floor(count*7680/19) one step at a time; wraps only past 1297
   assign rem_sum = rem_ff + REM_STEP;
   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      if (req_clear_counts) begin
         quot_in = '0;
         rem_in  = '0;
      end else if (motor_stepped) begin
         if (rem_sum >= STEP_DIVISOR) begin
            quot_in = quot_ff + QUOT_STEP + QUOT_WIDTH'(1);
            rem_in  = rem_sum - STEP_DIVISOR;
         end else begin
            quot_in = quot_ff + QUOT_STEP;
            rem_in  = rem_sum;
         end
      end
   end

   // Error in Q8 degrees from the count before this sample
   assign err_full = QUOT_WIDTH'({target_ff, FRAC_BITS'(0)}) - quot_ff;
   assign err      = err_full[ERR_WIDTH-1:0];

   // Accumulate the saturating integral on a tick; clear it at target
   assign integ_sum = {1'b0, integ_ff} + (INTEG_WIDTH + 1)'(err);
   always_comb begin
      integ_in = integ_ff;
      if (req_control_tick) begin
         if (!below_old) begin
            integ_in = '0;
         end else if (integ_sum[INTEG_WIDTH]) begin
            integ_in = '1;
         end else begin
            integ_in = integ_sum[INTEG_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quot_ff  <= '0;
         rem_ff   <= '0;
         integ_ff <= '0;
      end else if (accept) begin
         quot_ff  <= quot_in;
         rem_ff   <= rem_in;
         integ_ff <= integ_in;
      end
   end

   // Stage 1: capture the sample's error, integral and positions
   always_ff @(posedge clock) begin
      if (accept) begin
         err1_ff   <= err;
         integ1_ff <= integ_in;
         tick1_ff  <= req_control_tick;
         below1_ff <= below_old;
         clr1_ff   <= req_clear_counts;
         at1_ff    <= !below_new;
         mpos1_ff  <= POS_WIDTH'(motor_next);
         opos1_ff  <= POS_WIDTH'(optical_next);
      end
   end

   // Stage 2: apply both gains
   always_ff @(posedge clock) begin
      if (adv2) begin
         pprod2_ff <= PPROD_WIDTH'(prop_ff) * PPROD_WIDTH'(err1_ff);
         iprod2_ff <= IPROD_WIDTH'(int_ff) * IPROD_WIDTH'(integ1_ff);
         tick2_ff  <= tick1_ff;
         below2_ff <= below1_ff;
         clr2_ff   <= clr1_ff;
         at2_ff    <= at1_ff;
         mpos2_ff  <= mpos1_ff;
         opos2_ff  <= opos1_ff;
      end
   end

   // Stage 3: sum, drop the Q20 fraction and clamp to the duty range
   assign drive_sum     = SUM_WIDTH'(pprod2_ff) + SUM_WIDTH'(iprod2_ff);
   assign drive_shifted = drive_sum >> DRIVE_SHIFT;
   assign drive_clamped = ((drive_shifted >> DRIVE_WIDTH) != '0) ? '1
                          : drive_shifted[DRIVE_WIDTH-1:0];

   always_comb begin
      if (clr2_ff) begin
         drive_in = '0;
      end else if (tick2_ff) begin
         drive_in = below2_ff ? drive_clamped : '0;
      end else begin
         drive_in = drive_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_ff <= '0;
      end else if (adv3) begin
         drive_ff <= drive_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         at3_ff   <= at2_ff;
         mpos3_ff <= mpos2_ff;
         opos3_ff <= opos2_ff;
      end
   end

   assign rsp_valid            = v3_ff;
   assign rsp_motor_drive      = drive_ff;
   assign rsp_motor_position   = mpos3_ff;
   assign rsp_optical_position = opos3_ff;
   assign rsp_at_target        = at3_ff;

   // A tick at or above target leaves the integral at zero
   integ_clear_at_target: assert property (@(posedge clock) disable iff (reset)
      accept && req_control_tick && !below_old |=> integ_ff == '0)
      else $error("integral not cleared at target");

   // A cleared sample always reports zero drive
   drive_zero_on_clear: assert property (@(posedge clock) disable iff (reset)
      adv3 && clr2_ff |=> rsp_motor_drive == '0)
      else $error("drive not zero after clear");

   // Without clear the motor count moves by at most one step per transfer
   motor_single_step: assert property (@(posedge clock) disable iff (reset)
      accept && !req_clear_counts |=> (motor_count == $past(motor_count))
         || (motor_count == $past(motor_count) + COUNT_WIDTH'(1)))
      else $error("motor count jumped");

   // Without clear the optical count moves by exactly the step it flagged
   optical_step_tracks: assert property (@(posedge clock) disable iff (reset)
      accept && !req_clear_counts |=> optical_count
         == $past(optical_count) + COUNT_WIDTH'($past(optical_stepped)))
      else $error("optical count does not follow its step flag");

   // Input stalls only when every stage is full and the output is stalled
   stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> v1_ff && v2_ff && v3_ff && rsp_stall)
      else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire
